// ===== design/separable_fir_image_filter_defines.svh =====
// ----------------------------------------------------------------------------
// Separable FIR image filter - assertion macros
// Concurrent check wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_FIR_IMAGE_FILTER_DEFINES_SVH
`define SEPARABLE_FIR_IMAGE_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SFIR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfir: same-cycle check failed");
// next-cycle implication
`define SFIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfir: next-cycle check failed");
`else
`define SFIR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SFIR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/sfir_pkg.sv =====
// ----------------------------------------------------------------------------
// sfir_pkg
// Shared constants, types and tap arithmetic of the separable FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sfir_pkg;

   localparam int TAPS       = 7;
   localparam int LINES      = TAPS - 1;
   localparam int SHIFT      = 8;
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 8;
   localparam int PROD_W     = PIX_W + COEF_W;
   localparam int SUM_W      = PROD_W + 3;    // seven products
   localparam int WIDTH_W    = 12;
   localparam int ROWS_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = WIDTH_W;
   localparam int WORD_W     = LINES * PIX_W; // one column of the line store

   typedef logic [TAPS-1:0][COEF_W-1:0] coef_set_type;
   typedef logic [TAPS-1:0][PIX_W-1:0]  tap_set_type;
   typedef logic [TAPS-1:0][PROD_W-1:0] prod_set_type;

   localparam coef_set_type COEF_RESET =
      {8'd2, 8'd15, 8'd62, 8'd98, 8'd62, 8'd15, 8'd2};
   localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = 12'd2000;
   localparam logic [WIDTH_W-1:0] MIN_WIDTH        = 12'd7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_0,
      CSR_COEF_1,
      CSR_COEF_2,
      CSR_COEF_3,
      CSR_COEF_4,
      CSR_COEF_5,
      CSR_COEF_6,
      CSR_LINE_WIDTH
   } csr_index_type;

   typedef struct packed {
      logic use_mem;   // column 6 or later: touches the line store
      logic emit;      // also row 6 or later: produces a result
      logic last;      // last pixel of the row
   } ctrl_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             frame_start;
   } req_data_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             row_end;
   } rsp_data_type;

   // seven independent 8x8 products
   function automatic prod_set_type mul_taps(input coef_set_type c, input tap_set_type d);
      prod_set_type p;
      for (int i = 0; i < TAPS; i++) begin
         p[i] = PROD_W'(c[i]) * PROD_W'(d[i]);
      end
      return p;
   endfunction

   // sum of products, >> 8, clamp to 255
   function automatic logic [PIX_W-1:0] sum_sat(input prod_set_type p);
      logic [SUM_W-1:0]       acc;
      logic [SUM_W-SHIFT-1:0] hi;
      acc = '0;
      for (int i = 0; i < TAPS; i++) begin
         acc = acc + SUM_W'(p[i]);
      end
      hi = acc[SUM_W-1:SHIFT];
      if (|hi[SUM_W-SHIFT-1:PIX_W]) begin
         return '1;
      end
      return hi[PIX_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/sfir_stream_if.sv =====
// ----------------------------------------------------------------------------
// sfir_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfir_stream_if #(parameter type data_type = logic);

   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== design/separable_fir_image_filter.sv =====
// ----------------------------------------------------------------------------
// separable_fir_image_filter
// Streaming 7x7 separable FIR over raster pixels with a line store memory.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                      accepted when
//  --------  ---  ---------------------------  ---------------------
//  req_chan  in   pixel_in[7:0], frame_start   valid && ready
//  rsp_chan  out  pixel_out[7:0], row_end      valid && ready
//  csr_*     in   index[2:0], wdata[11:0]      csr_we
//
//  One pixel item per cycle while rsp_chan does not stall; the line store
//  takes one read and one write per cycle, which is what sets that rate.
//  A result leaves the output register after passing stages 1, 2 and 3.
//  Reset clears counters, row window and pipeline valids; the line store has
//  no clearing pass and holds garbage until the first six rows fill it.
//  Backpressure on rsp_chan stalls stage by stage: empty stages keep filling,
//  so req_chan.ready drops only when every stage holds an item.
//
`default_nettype none
`include "separable_fir_image_filter_defines.svh"

module separable_fir_image_filter #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   sfir_stream_if.sink                             req_chan,
   sfir_stream_if.source                           rsp_chan,
   input  wire logic                               csr_we,
   input  wire logic [sfir_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sfir_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // x = column - 6 addresses one 6-line column of the store
   localparam int DEPTH  = MAX_WIDTH - sfir_pkg::LINES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration registers
   sfir_pkg::coef_set_type             coef_ff;
   logic [sfir_pkg::WIDTH_W-1:0]       line_width_ff;

   // pipeline handshake: stage k loads whenever it is empty or draining
   logic en1, en2, en3, en_out;
   logic v1, v2, v3;

   sfir_pkg::ctrl_type                 ctrl1, ctrl2;
   logic [ADDR_W-1:0]                  x1, x2;
   logic [sfir_pkg::PIX_W-1:0]         h2;

   logic                               mem_rd_en, mem_wr_en;
   logic [ADDR_W-1:0]                  mem_rd_addr, mem_wr_addr;
   logic [sfir_pkg::WORD_W-1:0]        mem_rd_data, mem_wr_data;

   logic                               rsp_valid;
   sfir_pkg::rsp_data_type             rsp_data;

   // ------------------------------------------------------------------
   // CSR writes: the user must write only while idle; the block does not enforce it
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff       <= sfir_pkg::COEF_RESET;
         line_width_ff <= sfir_pkg::LINE_WIDTH_RESET;
      end else if (csr_we) begin
         case (sfir_pkg::csr_index_type'(csr_index))
            sfir_pkg::CSR_COEF_0, sfir_pkg::CSR_COEF_1, sfir_pkg::CSR_COEF_2,
            sfir_pkg::CSR_COEF_3, sfir_pkg::CSR_COEF_4, sfir_pkg::CSR_COEF_5,
            sfir_pkg::CSR_COEF_6: begin
               coef_ff[csr_index] <= csr_wdata[sfir_pkg::COEF_W-1:0];
            end
            sfir_pkg::CSR_LINE_WIDTH: begin
               line_width_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // stall chain, output side back to input side
   // ------------------------------------------------------------------
   assign en_out = !rsp_valid || rsp_chan.ready;
   assign en3    = !v3 || en_out;
   assign en2    = !v2 || en3;
   assign en1    = !v1 || en2;

   assign req_chan.ready = en1;

   // stages 1-2: counters, row window, horizontal FIR
   sfir_hpath #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_W    (ADDR_W)
   ) u_hpath (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_data    (req_chan.data),
      .load1      (en1),
      .load2      (en2),
      .coef       (coef_ff),
      .line_width (line_width_ff),
      .v1         (v1),
      .ctrl1      (ctrl1),
      .x1         (x1),
      .v2         (v2),
      .ctrl2      (ctrl2),
      .x2         (x2),
      .h2         (h2)
   );

   // ------------------------------------------------------------------
   // Line store read-modify-write. The column is read as the item moves
   // into stage 2 and written back, shifted up one line with the new
   // horizontal result on top, as it moves into stage 3. Two items that
   // hit the same column are at least a full row (7+ items) apart, so the
   // read of one never overlaps the pending write of another.
   // ------------------------------------------------------------------
   assign mem_rd_en   = en2 && v1 && ctrl1.use_mem;
   assign mem_rd_addr = x1;
   assign mem_wr_en   = en3 && v2 && ctrl2.use_mem;
   assign mem_wr_addr = x2;
   assign mem_wr_data = {h2, mem_rd_data[sfir_pkg::WORD_W-1:sfir_pkg::PIX_W]};

   sfir_line_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (sfir_pkg::WORD_W)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // stage 3 and output register: vertical FIR
   sfir_vpath u_vpath (
      .clock     (clock),
      .reset     (reset),
      .load3     (en3),
      .load_out  (en_out),
      .v2        (v2),
      .ctrl2     (ctrl2),
      .h2        (h2),
      .rd_word   (mem_rd_data),
      .coef      (coef_ff),
      .v3        (v3),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.data  = rsp_data;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   `SFIR_ASSERT_IMPL(a_no_column_overlap, clock, reset, mem_rd_en && mem_wr_en, mem_rd_addr != mem_wr_addr)
   `SFIR_ASSERT_IMPL(a_emit_needs_column, clock, reset, v1 && ctrl1.emit, ctrl1.use_mem)
   `SFIR_ASSERT_IMPL(a_rsp_from_stage3, clock, reset, $rose(rsp_valid), $past(v3))
   `SFIR_ASSERT_NEXT(a_bubble_no_rsp, clock, reset, en_out && !v3, !rsp_valid)

endmodule

`default_nettype wire

// ===== design/sfir_line_mem.sv =====
// ----------------------------------------------------------------------------
// sfir_line_mem
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfir_line_mem #(
   parameter int DEPTH  = 2042,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 48
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/sfir_hpath.sv =====
// ----------------------------------------------------------------------------
// sfir_hpath
// Column/row tracking, row window and horizontal 7-tap FIR (stages 1-2).
// ----------------------------------------------------------------------------
`default_nettype none

module sfir_hpath #(
   parameter int MAX_WIDTH = 2048,
   parameter int ADDR_W    = 11
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   input  wire sfir_pkg::req_data_type          in_data,
   input  wire logic                            load1,
   input  wire logic                            load2,
   input  wire sfir_pkg::coef_set_type          coef,
   input  wire logic [sfir_pkg::WIDTH_W-1:0]    line_width,
   output      logic                            v1,
   output      sfir_pkg::ctrl_type              ctrl1,
   output      logic [ADDR_W-1:0]               x1,
   output      logic                            v2,
   output      sfir_pkg::ctrl_type              ctrl2,
   output      logic [ADDR_W-1:0]               x2,
   output      logic [sfir_pkg::PIX_W-1:0]      h2
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = ((COL_W > sfir_pkg::WIDTH_W) ? COL_W : sfir_pkg::WIDTH_W) + 1;

   logic [COL_W-1:0]                                col_ff, col_in, col_cur;
   logic [sfir_pkg::ROWS_W-1:0]                     rows_ff, rows_in, rows_cur;
   logic [sfir_pkg::LINES-1:0][sfir_pkg::PIX_W-1:0] win_ff, win_in;
   sfir_pkg::tap_set_type                           taps;
   logic [CMP_W-1:0]                                lw_ext, eff_last;
   logic                                            accept, last_cur, use_cur;
   logic [ADDR_W-1:0]                               x_cur;

   logic                    v1_ff, v2_ff;
   sfir_pkg::ctrl_type      ctrl1_ff, ctrl2_ff;
   sfir_pkg::prod_set_type  prod1_ff;
   logic [ADDR_W-1:0]       x1_ff, x2_ff;
   logic [sfir_pkg::PIX_W-1:0] h2_ff;

   assign accept = in_valid && load1;

   always_comb begin
      col_cur  = in_data.frame_start ? '0 : col_ff;
      rows_cur = in_data.frame_start ? '0 : rows_ff;

      // clamp width into MIN_WIDTH..MAX_WIDTH, keep last column index
      lw_ext = CMP_W'(line_width);
      if (lw_ext < CMP_W'(sfir_pkg::MIN_WIDTH)) begin
         eff_last = CMP_W'(sfir_pkg::MIN_WIDTH) - CMP_W'(1);
      end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
         eff_last = CMP_W'(MAX_WIDTH - 1);
      end else begin
         eff_last = lw_ext - CMP_W'(1);
      end

      last_cur = CMP_W'(col_cur) >= eff_last;
      use_cur  = CMP_W'(col_cur) >= CMP_W'(sfir_pkg::LINES);
      x_cur    = ADDR_W'(col_cur - COL_W'(sfir_pkg::LINES));

      taps   = {in_data.pixel_in, win_ff};
      win_in = {in_data.pixel_in, win_ff[sfir_pkg::LINES-1:1]};

      col_in  = col_ff;
      rows_in = rows_ff;
      if (accept) begin
         if (last_cur) begin
            col_in  = '0;
            rows_in = (rows_cur < sfir_pkg::ROWS_W'(sfir_pkg::LINES)) ?
                      rows_cur + sfir_pkg::ROWS_W'(1) : rows_cur;
         end else begin
            col_in  = col_cur + COL_W'(1);
            rows_in = rows_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         rows_ff  <= '0;
         win_ff   <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
      end else begin
         col_ff  <= col_in;
         rows_ff <= rows_in;
         if (accept) begin
            win_ff <= win_in;
         end
         if (load1) begin
            v1_ff    <= in_valid;
            ctrl1_ff <= '{use_mem: use_cur,
                          emit:    use_cur && (rows_cur >= sfir_pkg::ROWS_W'(sfir_pkg::LINES)),
                          last:    last_cur};
         end
         if (load2) begin
            v2_ff    <= v1_ff;
            ctrl2_ff <= ctrl1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         prod1_ff <= sfir_pkg::mul_taps(coef, taps);
         x1_ff    <= x_cur;
      end
      if (load2) begin
         h2_ff <= sfir_pkg::sum_sat(prod1_ff);
         x2_ff <= x1_ff;
      end
   end

   assign v1    = v1_ff;
   assign ctrl1 = ctrl1_ff;
   assign x1    = x1_ff;
   assign v2    = v2_ff;
   assign ctrl2 = ctrl2_ff;
   assign x2    = x2_ff;
   assign h2    = h2_ff;

endmodule

`default_nettype wire

// ===== design/sfir_vpath.sv =====
// ----------------------------------------------------------------------------
// sfir_vpath
// Vertical 7-tap FIR over one line store column (stage 3) and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfir_vpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load3,
   input  wire logic                          load_out,
   input  wire logic                          v2,
   input  wire sfir_pkg::ctrl_type            ctrl2,
   input  wire logic [sfir_pkg::PIX_W-1:0]    h2,
   input  wire logic [sfir_pkg::WORD_W-1:0]   rd_word,
   input  wire sfir_pkg::coef_set_type        coef,
   output      logic                          v3,
   output      logic                          rsp_valid,
   output      sfir_pkg::rsp_data_type        rsp_data
);

   sfir_pkg::tap_set_type   vtaps;
   logic                    v3_ff, rsp_valid_ff;
   sfir_pkg::ctrl_type      ctrl3_ff;
   sfir_pkg::prod_set_type  prod3_ff;
   sfir_pkg::rsp_data_type  rsp_data_ff;

   // byte i of the column is line i, oldest row first; h2 is the newest row
   assign vtaps = {h2, rd_word};

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff        <= 1'b0;
         ctrl3_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load3) begin
            v3_ff    <= v2;
            ctrl3_ff <= ctrl2;
         end
         if (load_out) begin
            rsp_valid_ff <= v3_ff && ctrl3_ff.emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         prod3_ff <= sfir_pkg::mul_taps(coef, vtaps);
      end
      if (load_out) begin
         rsp_data_ff.pixel_out <= sfir_pkg::sum_sat(prod3_ff);
         rsp_data_ff.row_end   <= ctrl3_ff.last;
      end
   end

   assign v3        = v3_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb - separable FIR image filter testbench
// Streams raster pixels through the 7x7 separable filter and checks every
// filtered pixel against a cycle-free predictor kept in step with each
// accepted item. Covers tap saturation, width clamping, frame restarts,
// mid-row width shrink and a partial row at the widest line store, then
// random frames.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TAPS       = sfir_pkg::TAPS;
   localparam int LINES      = sfir_pkg::LINES;
   localparam int SHIFT      = sfir_pkg::SHIFT;
   localparam int PIX_W      = sfir_pkg::PIX_W;
   localparam int COEF_W     = sfir_pkg::COEF_W;
   localparam int WIDTH_W    = sfir_pkg::WIDTH_W;
   localparam int CSR_IDX_W  = sfir_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = sfir_pkg::CSR_DATA_W;

   localparam int MAX_W        = 2048;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 8;     // output register sits behind stages 1 to 3
   localparam int RANDOM_ITEMS = 400;
   localparam int NOISE_PCT    = 2;     // stray frame starts in random frames

   localparam sfir_pkg::csr_index_type COEF_REGS [TAPS] = '{
      sfir_pkg::CSR_COEF_0, sfir_pkg::CSR_COEF_1, sfir_pkg::CSR_COEF_2,
      sfir_pkg::CSR_COEF_3, sfir_pkg::CSR_COEF_4, sfir_pkg::CSR_COEF_5,
      sfir_pkg::CSR_COEF_6
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sfir_stream_if #(.data_type(sfir_pkg::req_data_type)) req_chan ();
   sfir_stream_if #(.data_type(sfir_pkg::rsp_data_type)) rsp_chan ();

   separable_fir_image_filter #(.MAX_WIDTH(MAX_W)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Predictor state: our own copy of the taps, width and pixel history
   // ---------------------------------------------------------------------
   logic [COEF_W-1:0]  tap_weight [TAPS];
   logic [WIDTH_W-1:0] line_width_reg;
   logic [PIX_W-1:0]   recent_pixels [LINES];          // oldest at index 0
   logic [PIX_W-1:0]   column_history [LINES][MAX_W];  // oldest row at index 0
   int unsigned        col_pos;
   int unsigned        rows_done;                      // saturates at LINES

   sfir_pkg::rsp_data_type filtered_q [$];      // filtered pixels still owed
   sfir_pkg::req_data_type pending_pixels [$];  // items waiting for the driver

   int  cycle_count = 0;
   int  mismatches  = 0;
   int  results_seen = 0;
   int  random_sent = 0;
   logic req_taken = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // sum of products >> 8, clamped to a byte
   function automatic logic [PIX_W-1:0] clip_byte(input int unsigned acc);
      int unsigned v;
      v = acc >> SHIFT;
      return (v > 255) ? '1 : v[PIX_W-1:0];
   endfunction

   // One accepted pixel: horizontal tap, vertical tap over the column history,
   // then advance the row window and the counters.
   function automatic void filter_pixel(input sfir_pkg::req_data_type item);
      int unsigned            w;
      int unsigned            col;
      int unsigned            x;
      int unsigned            h_acc;
      int unsigned            v_acc;
      logic [PIX_W-1:0]       h_pix;
      bit                     last_col;
      sfir_pkg::rsp_data_type res;
      w = line_width_reg;
      if (w < TAPS) w = TAPS;
      if (w > MAX_W) w = MAX_W;
      if (item.frame_start) begin
         col_pos   = 0;
         rows_done = 0;
      end
      col = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
      // a width shrunk below the current column ends the row right here
      last_col = (col >= w - 1);
      if (col >= LINES) begin
         x     = col - LINES;
         h_acc = 0;
         for (int i = 0; i < LINES; i++) h_acc += tap_weight[i] * recent_pixels[i];
         h_acc += tap_weight[LINES] * item.pixel_in;
         h_pix = clip_byte(h_acc);
         v_acc = 0;
         for (int i = 0; i < LINES; i++) v_acc += tap_weight[i] * column_history[i][x];
         v_acc += tap_weight[LINES] * h_pix;
         for (int i = 0; i < LINES - 1; i++) column_history[i][x] = column_history[i + 1][x];
         column_history[LINES - 1][x] = h_pix;
         if (rows_done >= LINES) begin
            res.pixel_out = clip_byte(v_acc);
            res.row_end   = last_col;
            filtered_q.push_back(res);
         end
      end
      for (int i = 0; i < LINES - 1; i++) recent_pixels[i] = recent_pixels[i + 1];
      recent_pixels[LINES - 1] = item.pixel_in;
      if (last_col) begin
         col_pos = 0;
         if (rows_done < LINES) rows_done++;
      end else begin
         col_pos = col + 1;
      end
   endfunction

   function automatic void check_result(input sfir_pkg::rsp_data_type got);
      sfir_pkg::rsp_data_type want;
      results_seen++;
      if (filtered_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: result %0d not expected: pixel_out=%0d row_end=%0b",
                     results_seen, got.pixel_out, got.row_end);
      end else begin
         want = filtered_q.pop_front();
         if (got.pixel_out !== want.pixel_out || got.row_end !== want.row_end) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result %0d: expected pixel_out=%0d row_end=%0b, got %0d/%0b",
                        results_seen, want.pixel_out, want.row_end,
                        got.pixel_out, got.row_end);
         end
      end
   endfunction

   // ~26% idle on each side, except for one quiet window with none at all
   function automatic bit idle_now();
      if (cycle_count >= 400 && cycle_count < 1000) return 1'b0;
      return $urandom_range(99) < 26;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: prediction on input accept, compare on result accept
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken   <= req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) filter_pixel(req_chan.data);
         if (rsp_chan.valid && rsp_chan.ready) check_result(rsp_chan.data);
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL separable_fir_image_filter");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Driver: everything changes on the falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         rsp_chan.ready <= 1'b0;
      end else begin
         // hold the current item until it is taken
         if (!req_chan.valid || req_taken) begin
            if (pending_pixels.size() != 0 && !idle_now()) begin
               req_chan.data  <= pending_pixels.pop_front();
               req_chan.valid <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         rsp_chan.ready <= !idle_now();
      end
   end

   // register write; the predictor copy follows at once since the block is idle
   task automatic write_reg(input sfir_pkg::csr_index_type idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == sfir_pkg::CSR_LINE_WIDTH) line_width_reg = value;
      else tap_weight[idx] = value[COEF_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // upper data bits are junk for tap registers and must be dropped
   task automatic write_taps(input sfir_pkg::coef_set_type w);
      for (int i = 0; i < TAPS; i++)
         write_reg(COEF_REGS[i], {4'($urandom_range(15)), w[i]});
   endtask

   // level < 0 means random pixels, biased toward the extremes
   task automatic queue_stream(input int count, input bit restart, input int noise_pct,
                               input int level);
      sfir_pkg::req_data_type item;
      for (int n = 0; n < count; n++) begin
         if (level >= 0) begin
            item.pixel_in = level[PIX_W-1:0];
         end else begin
            case ($urandom_range(7))
               0:       item.pixel_in = '0;
               1:       item.pixel_in = '1;
               default: item.pixel_in = PIX_W'($urandom_range(255));
            endcase
         end
         item.frame_start = (n == 0) ? restart : ($urandom_range(99) < noise_pct);
         pending_pixels.push_back(item);
      end
   endtask

   // sender holds off until every owed result is back, then waits out a drain period
   task automatic settle();
      while (pending_pixels.size() != 0 || req_chan.valid || filtered_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int                     raw;
      int                     eff;
      int                     narrow;
      int                     rows;
      int                     split_rows;
      int                     count;
      int                     sel;
      sfir_pkg::coef_set_type taps;

      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = sfir_pkg::CSR_COEF_0;
      csr_wdata      = '0;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;

      for (int i = 0; i < TAPS; i++) tap_weight[i] = sfir_pkg::COEF_RESET[i];
      line_width_reg = sfir_pkg::LINE_WIDTH_RESET;
      for (int i = 0; i < LINES; i++) recent_pixels[i] = '0;
      col_pos   = 0;
      rows_done = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Saturation: all taps 255 on an all-white frame; width 0 clamps to 7.
      write_reg(sfir_pkg::CSR_LINE_WIDTH, 12'd0);
      write_taps('1);
      queue_stream(8 * TAPS, 1'b1, 0, 255);
      settle();

      // Width above range clamps to MAX_W; all taps zero. A short row, then
      // the width drops below the current column so the next pixel ends it.
      write_reg(sfir_pkg::CSR_LINE_WIDTH, 12'd4095);
      write_taps('0);
      queue_stream(31, 1'b1, 0, -1);
      settle();
      write_reg(sfir_pkg::CSR_LINE_WIDTH, 12'd7);
      queue_stream(1 + LINES * TAPS, 1'b0, 0, -1);
      settle();

      // Width shrink in the emitting region, with a tap change in the pause:
      // the first pixel after the pause ends row 6 with a result.
      for (int i = 0; i < TAPS; i++) taps[i] = COEF_W'($urandom_range(255));
      write_taps(taps);
      write_reg(sfir_pkg::CSR_LINE_WIDTH, 12'd16);
      queue_stream(LINES * 16 + 12, 1'b1, 0, -1);
      settle();
      write_reg(sfir_pkg::CSR_LINE_WIDTH, 12'd8);
      write_reg(sfir_pkg::CSR_COEF_3, 12'd0);
      queue_stream(1 + 8, 1'b0, 0, -1);
      settle();

      // Part of a first row at the widest line store, default taps.
      write_taps(sfir_pkg::COEF_RESET);
      write_reg(sfir_pkg::CSR_LINE_WIDTH, 12'd2048);
      queue_stream(40, 1'b1, 0, -1);
      settle();

      // Random frames, mostly narrow so results come often.
      while (random_sent < RANDOM_ITEMS) begin
         sel = $urandom_range(99);
         if (sel < 70)      raw = $urandom_range(20, 7);
         else if (sel < 82) raw = $urandom_range(6, 0);
         else if (sel < 94) raw = $urandom_range(64, 21);
         else               raw = $urandom_range(4095, 2049);
         eff = (raw < TAPS) ? TAPS : ((raw > MAX_W) ? MAX_W : raw);

         case ($urandom_range(9))
            0:       taps = '1;
            1:       taps = '0;
            2:       taps = sfir_pkg::COEF_RESET;
            default: for (int i = 0; i < TAPS; i++) taps[i] = COEF_W'($urandom_range(255));
         endcase
         write_taps(taps);
         write_reg(sfir_pkg::CSR_LINE_WIDTH, raw[CSR_DATA_W-1:0]);

         if (eff > 64) begin
            // wide lines: a partial first row only, no results expected
            count = $urandom_range(80, 20);
            queue_stream(count, 1'b1, NOISE_PCT, -1);
            random_sent += count;
         end else begin
            rows = $urandom_range(10, 7);
            if ($urandom_range(3) == 0) begin
               // pause mid-frame, then maybe narrow the line and retune a tap
               split_rows = $urandom_range(rows - 1, 1);
               count      = split_rows * eff + $urandom_range(eff - 1, 0);
               queue_stream(count, 1'b1, NOISE_PCT, -1);
               random_sent += count;
               settle();
               if ($urandom_range(1) == 1) begin
                  narrow = $urandom_range(eff, 3);
                  write_reg(sfir_pkg::CSR_LINE_WIDTH, narrow[CSR_DATA_W-1:0]);
                  eff = (narrow < TAPS) ? TAPS : narrow;
               end
               if ($urandom_range(1) == 1)
                  write_reg(COEF_REGS[$urandom_range(TAPS - 1)], 12'($urandom_range(4095)));
               count = (rows - split_rows) * eff;
               queue_stream(count, 1'b0, NOISE_PCT, -1);
               random_sent += count;
            end else begin
               count = rows * eff;
               queue_stream(count, 1'b1, NOISE_PCT, -1);
               random_sent += count;
            end
         end
         settle();
      end

      settle();
      if (mismatches == 0) begin
         $display("PASS separable_fir_image_filter");
      end else begin
         $display("FAIL separable_fir_image_filter");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/sfir_pkg.sv
design/sfir_stream_if.sv
design/sfir_line_mem.sv
design/sfir_hpath.sv
design/sfir_vpath.sv
design/separable_fir_image_filter.sv
dv/tb.sv
